// ===== rtl/pppe_pkg.sv =====
// Shared types, constants and register indexes of the planar pixel plot engine.
package pppe_pkg;

    // Store geometry: one word holds a 16-pixel group over all planes
    localparam int PLANES      = 4;
    localparam int STORE_WORDS = 65536;
    localparam int ADDR_W      = $clog2(STORE_WORDS);
    localparam int GROUP_PIX   = 16;
    localparam int WORD_W      = GROUP_PIX * PLANES;

    // Leftmost pixel of a group and the in-group column mask
    localparam logic [15:0] PIX_MSB      = 16'h8000;
    localparam logic [3:0]  PIX_IDX_MASK = 4'd15;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_X_MIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_Y_MIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_X_MAX   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_Y_MAX   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAW_MODE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_WORDS_PER_LN = 3'd7;

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_DRAW   = 2'd1,
        MODE_TRANSP = 2'd2,
        MODE_INVERT = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_PLOT    = 2'd0,
        KIND_PATTERN = 2'd1,
        KIND_READ    = 2'd2,
        KIND_NONE    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_MUL  = 2'd1,
        ST_RD   = 2'd2,
        ST_WB   = 2'd3
    } t_state;

    // Live configuration seen by the datapath
    typedef struct packed {
        logic signed [15:0] clip_x_min;
        logic signed [15:0] clip_y_min;
        logic signed [15:0] clip_x_max;
        logic signed [15:0] clip_y_max;
        t_mode              draw_mode;
        logic [3:0]         fg_color;
        logic [3:0]         bg_color;
        logic [12:0]        words_per_line;
    } t_cfg;

endpackage

// ===== rtl/pppe_cfg.sv =====
// Configuration register file of the planar pixel plot engine.
module pppe_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pppe_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [15:0]                       i_cfg_wdata,
    output pppe_pkg::t_cfg                    o_cfg
);
    import pppe_pkg::*;

    t_cfg r_cfg;

    // Load the addressed register, restore defaults on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clip_x_min     <= 16'sd0;
            r_cfg.clip_y_min     <= 16'sd0;
            r_cfg.clip_x_max     <= 16'sd32767;
            r_cfg.clip_y_max     <= 16'sd32767;
            r_cfg.draw_mode      <= MODE_DRAW;
            r_cfg.fg_color       <= 4'd15;
            r_cfg.bg_color       <= 4'd0;
            r_cfg.words_per_line <= 13'd40;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_CLIP_X_MIN:   r_cfg.clip_x_min     <= i_cfg_wdata;
                CFG_CLIP_Y_MIN:   r_cfg.clip_y_min     <= i_cfg_wdata;
                CFG_CLIP_X_MAX:   r_cfg.clip_x_max     <= i_cfg_wdata;
                CFG_CLIP_Y_MAX:   r_cfg.clip_y_max     <= i_cfg_wdata;
                CFG_DRAW_MODE:    r_cfg.draw_mode      <= t_mode'(i_cfg_wdata[1:0]);
                CFG_FG_COLOR:     r_cfg.fg_color       <= i_cfg_wdata[3:0];
                CFG_BG_COLOR:     r_cfg.bg_color       <= i_cfg_wdata[3:0];
                CFG_WORDS_PER_LN: r_cfg.words_per_line <= i_cfg_wdata[12:0];
                default:          r_cfg.words_per_line <= r_cfg.words_per_line;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/pppe_store.sv =====
// Frame store memory with registered read and a zeroing sweep after reset.
module pppe_store (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_rd_en,
    input  logic [pppe_pkg::ADDR_W-1:0]       i_rd_addr,
    output logic [pppe_pkg::WORD_W-1:0]       o_rd_data,
    input  logic                              i_wr_en,
    input  logic [pppe_pkg::ADDR_W-1:0]       i_wr_addr,
    input  logic [pppe_pkg::WORD_W-1:0]       i_wr_data,
    output logic                              o_clearing
);
    import pppe_pkg::*;

    logic [WORD_W-1:0] r_mem [STORE_WORDS];
    logic [WORD_W-1:0] r_rd_data;
    logic [ADDR_W-1:0] r_clr_addr;
    logic              r_clearing;

    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [WORD_W-1:0] w_wdata;

    // Sweep every word to zero once after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
            if (&r_clr_addr) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Pick the sweep or the datapath as the write source
    always_comb begin
        w_we    = r_clearing | i_wr_en;
        w_waddr = r_clearing ? r_clr_addr : i_wr_addr;
        w_wdata = r_clearing ? '0 : i_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
    end

    // Hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clearing;

endmodule

// ===== rtl/planar_pixel_plot_engine_unit.sv =====
// Top level: request sequencer, read-modify-write datapath and result register.
// Result: registered at write back, which waits while the previous result is not yet taken.
// Each item steps through accept, address multiply, store read and write back.
// Items do not overlap: one store read-modify-write finishes before the next accept.
// Reset zeroes the frame store in a sweep over all 65536 words; no beat is taken meanwhile.
// Configuration writes are taken at any time, including during the sweep.
module planar_pixel_plot_engine_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pppe_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [15:0]                       i_cfg_wdata,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [1:0]                        i_kind,
    input  logic signed [15:0]                i_x,
    input  logic signed [15:0]                i_y,
    input  logic [15:0]                       i_pattern_row,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_clipped,
    output logic [3:0]                        o_pixel_color
);
    import pppe_pkg::*;

    t_cfg              w_cfg;
    logic              w_clearing;
    logic [WORD_W-1:0] w_rd_data;

    t_state r_state, n_state;

    // Request fields captured at accept
    t_kind              r_kind;
    logic signed [15:0] r_x;
    logic signed [15:0] r_y;
    logic [15:0]        r_pat;

    // Operation decoded in the multiply cycle
    logic [ADDR_W-1:0]  r_prod;
    logic               r_clip;
    logic               r_write;
    logic               r_tgl;
    logic [15:0]        r_mask;
    logic [3:0]         r_col;
    logic [15:0]        r_bit;
    logic [ADDR_W-1:0]  r_addr;

    // Result register
    logic               r_out_valid;
    logic               r_out_clipped;
    logic [3:0]         r_out_color;

    logic               w_accept;
    logic               w_out_free;
    logic               w_wb_go;
    logic               w_rd_en;
    logic signed [29:0] w_prod;
    logic [30:0]        w_grp;
    logic [ADDR_W-1:0]  w_addr;
    logic               w_clip;
    logic [15:0]        w_bit;
    logic [15:0]        w_set;
    logic               w_write;
    logic               w_tgl;
    logic [15:0]        w_mask;
    logic [3:0]         w_col;
    logic [WORD_W-1:0]  w_new_word;
    logic [3:0]         w_rd_color;

    pppe_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    pppe_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (w_rd_en),
        .i_rd_addr  (w_addr),
        .o_rd_data  (w_rd_data),
        .i_wr_en    (w_wb_go & r_write),
        .i_wr_addr  (r_addr),
        .i_wr_data  (w_new_word),
        .o_clearing (w_clearing)
    );

    // Sequence one item through multiply, read and write back
    always_comb begin
        n_state    = r_state;
        o_ready    = (r_state == ST_IDLE) & ~w_clearing;
        w_accept   = i_valid & o_ready;
        w_out_free = ~r_out_valid | i_ready;
        w_wb_go    = (r_state == ST_WB) & w_out_free;
        w_rd_en    = (r_state == ST_RD);
        case (r_state)
            ST_IDLE: if (w_accept) n_state = ST_MUL;
            ST_MUL:  n_state = ST_RD;
            ST_RD:   n_state = ST_WB;
            ST_WB:   if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the request beat
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= t_kind'(i_kind);
            r_x    <= i_x;
            r_y    <= i_y;
            r_pat  <= i_pattern_row;
        end
    end

    // Line product, clip test, pixel bit and plot operation
    always_comb begin
        w_prod  = 30'(r_y) * 30'($signed({1'b0, w_cfg.words_per_line}));
        w_clip  = (r_x < w_cfg.clip_x_min) | (r_x > w_cfg.clip_x_max) |
                  (r_y < w_cfg.clip_y_min) | (r_y > w_cfg.clip_y_max);
        w_bit   = PIX_MSB >> (r_x[3:0] & PIX_IDX_MASK);
        w_set   = w_bit & r_pat;
        w_write = 1'b0;
        w_tgl   = 1'b0;
        w_mask  = w_bit;
        w_col   = w_cfg.fg_color;
        case (r_kind)
            KIND_PLOT: begin
                w_write = 1'b1;
                case (w_cfg.draw_mode)
                    MODE_CLEAR:  w_col = w_cfg.bg_color;
                    MODE_INVERT: w_tgl = 1'b1;
                    default:     w_col = w_cfg.fg_color;
                endcase
            end
            KIND_PATTERN: begin
                w_write = 1'b1;
                case (w_cfg.draw_mode)
                    MODE_CLEAR: begin
                        w_mask = w_set;
                        w_col  = w_cfg.bg_color;
                    end
                    MODE_DRAW: begin
                        w_col = (|w_set) ? w_cfg.fg_color : w_cfg.bg_color;
                    end
                    MODE_TRANSP: w_mask = w_set;
                    default: begin
                        w_mask = w_set;
                        w_tgl  = 1'b1;
                    end
                endcase
            end
            default: w_write = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_MUL) begin
            r_prod  <= w_prod[ADDR_W-1:0];
            r_clip  <= w_clip;
            r_write <= w_write & ~w_clip;
            r_tgl   <= w_tgl;
            r_mask  <= w_mask;
            r_col   <= w_col;
            r_bit   <= w_bit;
        end
    end

    // Add the group column; the store size wraps the word address
    always_comb begin
        w_grp  = {{19{r_x[15]}}, r_x[15:4]};
        w_addr = r_prod + w_grp[ADDR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_addr <= w_addr;
        end
    end

    // Modify the active planes and pick out the read pixel
    always_comb begin
        w_new_word = w_rd_data;
        w_rd_color = 4'd0;
        for (int p = 0; p < PLANES; p++) begin
            if (r_tgl) begin
                w_new_word[GROUP_PIX*p +: GROUP_PIX] =
                    w_rd_data[GROUP_PIX*p +: GROUP_PIX] ^ r_mask;
            end else begin
                w_new_word[GROUP_PIX*p +: GROUP_PIX] =
                    (w_rd_data[GROUP_PIX*p +: GROUP_PIX] & ~r_mask) |
                    (r_col[p] ? r_mask : 16'd0);
            end
            w_rd_color[p] = |(w_rd_data[GROUP_PIX*p +: GROUP_PIX] & r_bit);
        end
    end

    // Hold the result beat until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_wb_go) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wb_go) begin
            r_out_clipped <= r_clip & (r_kind != KIND_NONE);
            r_out_color   <= (r_kind == KIND_READ && !r_clip) ? w_rd_color : 4'd0;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_clipped     = r_out_clipped;
    assign o_pixel_color = r_out_color;

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the planar pixel plot engine: plots, pattern plots and pixel reads.
module testbench;
    import pppe_pkg::*;

    localparam int RUN_LIMIT  = 400000;
    localparam int SETTLE_CYC = 8;
    localparam int HOLD_CYC   = 400;
    localparam int HOLD_AT    = 160;

    typedef struct packed {
        t_kind              kind;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [15:0]        pattern_row;
    } t_pix_req;

    typedef struct packed {
        logic       clipped;
        logic [3:0] pixel_color;
    } t_pix_res;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_addr    = '0;
    logic [15:0]          i_cfg_wdata   = '0;
    logic                 i_valid       = 1'b0;
    logic [1:0]           i_kind        = '0;
    logic signed [15:0]   i_x           = '0;
    logic signed [15:0]   i_y           = '0;
    logic [15:0]          i_pattern_row = '0;
    logic                 i_ready       = 1'b0;
    logic                 o_ready;
    logic                 o_valid;
    logic                 o_clipped;
    logic [3:0]           o_pixel_color;

    // Mirror of the frame store and of the live register set
    bit [WORD_W-1:0] frame_mirror [STORE_WORDS];
    t_cfg            cfg_now;

    t_pix_req plot_requests [$];
    t_pix_res pixel_outcomes [$];
    t_pix_req offered;
    t_pix_res outcome;
    t_pix_res want;

    int   cycle_count     = 0;
    int   requests_queued = 0;
    int   results_seen    = 0;
    int   clipped_seen    = 0;
    int   lit_reads       = 0;
    int   mismatches      = 0;
    int   setups          = 0;
    int   stall_left      = 0;
    bit   steady          = 1'b0;

    t_mode mode_order [4] = '{MODE_DRAW, MODE_CLEAR, MODE_INVERT, MODE_TRANSP};

    planar_pixel_plot_engine_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_kind        (i_kind),
        .i_x           (i_x),
        .i_y           (i_y),
        .i_pattern_row (i_pattern_row),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_clipped     (o_clipped),
        .o_pixel_color (o_pixel_color)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Set or clear the selected pixels in every active plane
    function automatic logic [WORD_W-1:0] paint_planes(logic [WORD_W-1:0] w, logic [15:0] m,
                                                       logic [3:0] col);
        int p;
        for (p = 0; p < PLANES; p++) begin
            w[16*p +: 16] = col[p] ? (w[16*p +: 16] | m) : (w[16*p +: 16] & ~m);
        end
        return w;
    endfunction

    // Apply one request to the mirror and return the result it should produce
    function automatic t_pix_res apply_to_frame(t_pix_req rq);
        t_pix_res          res;
        int                px;
        int                py;
        int                addr;
        int                p;
        logic [15:0]       pix_bit;
        logic [15:0]       sel;
        logic [WORD_W-1:0] w;
        res = '0;
        px  = rq.x;
        py  = rq.y;
        if (rq.kind == KIND_NONE) return res;
        if (px < cfg_now.clip_x_min || px > cfg_now.clip_x_max ||
            py < cfg_now.clip_y_min || py > cfg_now.clip_y_max) begin
            res.clipped = 1'b1;
            return res;
        end
        addr = (py * int'(cfg_now.words_per_line) + (px >>> 4)) % STORE_WORDS;
        if (addr < 0) addr += STORE_WORDS;
        pix_bit = PIX_MSB >> (px & 15);
        sel     = pix_bit & rq.pattern_row;
        w       = frame_mirror[addr];
        case (rq.kind)
            KIND_READ: begin
                for (p = 0; p < PLANES; p++) res.pixel_color[p] = |(w[16*p +: 16] & pix_bit);
            end
            KIND_PLOT: begin
                case (cfg_now.draw_mode)
                    MODE_CLEAR:  w = paint_planes(w, pix_bit, cfg_now.bg_color);
                    MODE_INVERT: w = w ^ {PLANES{pix_bit}};
                    default:     w = paint_planes(w, pix_bit, cfg_now.fg_color);
                endcase
            end
            default: begin
                case (cfg_now.draw_mode)
                    MODE_CLEAR:  w = paint_planes(w, sel, cfg_now.bg_color);
                    MODE_DRAW:   w = paint_planes(w, pix_bit,
                                                  (sel != 0) ? cfg_now.fg_color : cfg_now.bg_color);
                    MODE_TRANSP: w = paint_planes(w, sel, cfg_now.fg_color);
                    default:     w = w ^ {PLANES{sel}};
                endcase
            end
        endcase
        frame_mirror[addr] = w;
        return res;
    endfunction

    task automatic log_mismatch(input string what);
        $display("MISMATCH cycle %0d: %s", cycle_count, what);
        mismatches++;
    endtask

    // Write one register and track it in the mirror
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_CLIP_X_MIN: cfg_now.clip_x_min     = val;
            CFG_CLIP_Y_MIN: cfg_now.clip_y_min     = val;
            CFG_CLIP_X_MAX: cfg_now.clip_x_max     = val;
            CFG_CLIP_Y_MAX: cfg_now.clip_y_max     = val;
            CFG_DRAW_MODE:  cfg_now.draw_mode      = t_mode'(val[1:0]);
            CFG_FG_COLOR:   cfg_now.fg_color       = val[3:0];
            CFG_BG_COLOR:   cfg_now.bg_color       = val[3:0];
            default:        cfg_now.words_per_line = val[12:0];
        endcase
    endtask

    // Program a full register set; unused upper bits carry junk
    task automatic load_setup(input int xmin, input int ymin, input int xmax, input int ymax,
                              input t_mode mode, input logic [3:0] fg, input logic [3:0] bg,
                              input int wpl);
        logic [15:0] junk;
        junk = 16'($urandom);
        write_reg(CFG_CLIP_X_MIN, 16'(xmin));
        write_reg(CFG_CLIP_Y_MIN, 16'(ymin));
        write_reg(CFG_CLIP_X_MAX, 16'(xmax));
        write_reg(CFG_CLIP_Y_MAX, 16'(ymax));
        write_reg(CFG_DRAW_MODE, {junk[15:2], mode});
        write_reg(CFG_FG_COLOR, {junk[15:4], fg});
        write_reg(CFG_BG_COLOR, {junk[15:4], bg});
        write_reg(CFG_WORDS_PER_LN, {junk[15:13], 13'(wpl)});
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        setups++;
    endtask

    task automatic queue_request(input t_kind k, input int x, input int y, input logic [15:0] pat);
        t_pix_req rq;
        rq.kind        = k;
        rq.x           = 16'(x);
        rq.y           = 16'(y);
        rq.pattern_row = pat;
        plot_requests.push_back(rq);
        requests_queued++;
    endtask

    function automatic int pick_rim(int lo, int hi);
        case ($urandom_range(3))
            0:       return lo - 1;
            1:       return lo;
            2:       return hi;
            default: return hi + 1;
        endcase
    endfunction

    // Mostly points in a small window so reads land on painted words
    task automatic queue_random(input int bx, input int by);
        int    pick;
        int    kpick;
        int    x;
        int    y;
        t_kind k;
        pick  = $urandom_range(99);
        kpick = $urandom_range(99);
        k = (kpick < 35) ? KIND_PLOT : (kpick < 65) ? KIND_PATTERN :
            (kpick < 95) ? KIND_READ : KIND_NONE;
        if (pick < 75) begin
            x = bx - 4 + int'($urandom_range(0, 47));
            y = by - 1 + int'($urandom_range(0, 6));
        end else if (pick < 87) begin
            x = pick_rim(cfg_now.clip_x_min, cfg_now.clip_x_max);
            y = pick_rim(cfg_now.clip_y_min, cfg_now.clip_y_max);
        end else begin
            x = int'($urandom);
            y = int'($urandom);
        end
        queue_request(k, x, y, 16'($urandom));
    endtask

    // Wait for every result, then let the engine settle before touching registers
    task automatic drain_batch();
        while (results_seen < requests_queued) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // Sender: predict on each accepted beat, then offer the next one or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                outcome = apply_to_frame(offered);
                pixel_outcomes.push_back(outcome);
            end
            if (!i_valid || o_ready) begin
                if (plot_requests.size() != 0 && (steady || $urandom_range(99) >= 18)) begin
                    offered = plot_requests.pop_front();
                    i_valid       <= 1'b1;
                    i_kind        <= offered.kind;
                    i_x           <= offered.x;
                    i_y           <= offered.y;
                    i_pattern_row <= offered.pattern_row;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each result beat against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (pixel_outcomes.size() == 0) begin
                    log_mismatch("result beat with no request outstanding");
                end else begin
                    want = pixel_outcomes.pop_front();
                    if (o_clipped !== want.clipped)
                        log_mismatch($sformatf("clipped %0b, predicted %0b",
                                               o_clipped, want.clipped));
                    if (o_pixel_color !== want.pixel_color)
                        log_mismatch($sformatf("pixel_color %h, predicted %h",
                                               o_pixel_color, want.pixel_color));
                    if (want.clipped) clipped_seen++;
                    if (want.pixel_color != 0) lit_reads++;
                end
                results_seen++;
                // hold off once mid-run so the engine backs up into its input
                if (results_seen == HOLD_AT) stall_left = HOLD_CYC;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= steady || ($urandom_range(99) >= 18);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int    ph;
        int    bx;
        int    by;
        int    wpl;
        logic [3:0] fg;
        logic [3:0] bg;
        bx = 0;
        by = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: full clip, draw mode, coordinate extremes, unused kind
        load_setup(-32768, -32768, 32767, 32767, MODE_DRAW, 4'hA, 4'h5, 40);
        queue_request(KIND_PLOT, 0, 0, 16'h0000);
        queue_request(KIND_READ, 0, 0, 16'h0000);
        queue_request(KIND_PATTERN, 1, 0, 16'h4000);
        queue_request(KIND_PATTERN, 2, 0, 16'hDFFF);
        queue_request(KIND_READ, 1, 0, 16'hFFFF);
        queue_request(KIND_READ, 2, 0, 16'h0000);
        queue_request(KIND_READ, 15, 0, 16'h0000);
        queue_request(KIND_PLOT, -32768, -32768, 16'hFFFF);
        queue_request(KIND_READ, -32768, -32768, 16'h0000);
        queue_request(KIND_PLOT, 32767, 32767, 16'h0000);
        queue_request(KIND_READ, 32767, 32767, 16'h0000);
        queue_request(KIND_NONE, -1, -1, 16'hFFFF);
        drain_batch();

        // Directed: invert inside a small clip window, zero line width, edges just outside
        load_setup(10, 5, 20, 6, MODE_INVERT, 4'h3, 4'hC, 0);
        queue_request(KIND_PLOT, 10, 5, 16'h0000);
        queue_request(KIND_READ, 10, 5, 16'h0000);
        queue_request(KIND_PATTERN, 11, 5, 16'h0010);
        queue_request(KIND_PATTERN, 12, 5, 16'hFFF7);
        queue_request(KIND_READ, 11, 5, 16'h0000);
        queue_request(KIND_READ, 12, 5, 16'h0000);
        queue_request(KIND_PLOT, 9, 5, 16'h0000);
        queue_request(KIND_READ, 21, 6, 16'h0000);
        queue_request(KIND_PLOT, 10, 4, 16'h0000);
        queue_request(KIND_PATTERN, 20, 7, 16'h0000);
        drain_batch();

        // Directed: empty clip rectangle clips everything
        load_setup(100, 0, 50, 10, MODE_TRANSP, 4'h1, 4'h2, 1);
        queue_request(KIND_PATTERN, 75, 0, 16'hFFFF);
        queue_request(KIND_READ, 75, 0, 16'h0000);
        queue_request(KIND_PLOT, -1, 3, 16'h0000);
        drain_batch();

        // Random batches across modes, colours, line widths and clip shapes
        for (ph = 0; ph < 8; ph++) begin
            if (ph == 0 || ph == 4) begin
                bx = int'($urandom_range(0, 63900)) - 32000;
                by = int'($urandom_range(0, 63900)) - 32000;
            end
            case (ph)
                0:       wpl = 1;
                1:       wpl = 4096;
                2:       wpl = 8191;
                3:       wpl = 0;
                4:       wpl = 40;
                default: wpl = int'($urandom_range(1, 8191));
            endcase
            fg = (ph == 0) ? 4'hF : (ph == 1) ? 4'h0 : 4'($urandom);
            bg = (ph == 0) ? 4'h0 : (ph == 1) ? 4'hF : 4'($urandom);
            if (ph == 0)
                load_setup(-32768, -32768, 32767, 32767, mode_order[ph % 4], fg, bg, wpl);
            else if (ph == 5)
                load_setup(bx + 40, by, bx, by + 4, mode_order[ph % 4], fg, bg, wpl);
            else
                load_setup(bx, by, bx + 40, by + 4, mode_order[ph % 4], fg, bg, wpl);
            steady = (ph == 3);
            repeat (84) queue_random(bx, by);
            drain_batch();
        end
        steady = 1'b0;

        $display("Covered %0d requests over %0d register setups: all modes, clip edges,",
                 results_seen, setups);
        $display("empty clip, zero/oversize line widths; %0d clipped, %0d lit reads, %0d errors",
                 clipped_seen, lit_reads, mismatches);
        if (mismatches == 0 && pixel_outcomes.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
